/* rtl/assert_macros.svh */
// assertion macros for the rtl files; only lru_k_frame_replacer includes them
// no dependencies; the enclosing module must have clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

/* rtl/lkr_pkg.sv */
// shared types, codes and sizes of the lru-k frame replacer
// no dependencies
package lkr_pkg;

  localparam int FRAME_COUNT = 64;
  localparam int FRAME_W     = $clog2(FRAME_COUNT);
  localparam int ID_W        = 8;
  localparam int CNT_W       = 4;
  localparam int STAMP_W     = 32;
  localparam int TOTAL_W     = 7;
  localparam int VFRAME_W    = 6;
  localparam int K_MIN       = 2;
  localparam int K_RESET     = 2;
  localparam int CNT_MAX     = 15;

  // operation codes
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_SET_EV = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_EVICT  = 2'd3;

  // status codes
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_NO_VICTIM = 2'd1;
  localparam logic [1:0] STS_INVALID   = 2'd2;
  localparam logic [1:0] STS_PINNED    = 2'd3;

  typedef struct packed {
    logic [1:0]      operation;
    logic [ID_W-1:0] frame_sel;
    logic            evictable_flag;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic                victim_valid;
    logic [VFRAME_W-1:0] victim_frame;
    logic [TOTAL_W-1:0]  evictable_count;
  } rsp_t;

  // one frame's entry in the stamp memory
  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

/* rtl/lru_k_frame_replacer.sv */
// top level of the lru-k frame replacer: sequencer, frame flags, victim scan
// depends on lkr_pkg, lkr_ram and assert_macros.svh
//
// Usage:
//   A request on in_req is taken at a rising edge with start high and busy low.
//   Each request gives one result on out_rsp, shown for one cycle with
//   out_valid high; the receiver cannot stall it and must take it then.
//   The history_k register is written over cfg_data when cfg_valid and
//   cfg_ready are high; cfg_ready is low while a request is in work.
// Result paths through the sequencer states:
//   mark updates, removes, out-of-range frames, access to a new frame: from ST_IDLE
//   access to a tracked frame: via ST_UPD (read-modify-write of the stamp ram)
//   evict, or access to a new frame with all frames evictable:
//     through ST_SCAN and then ST_FIN; the scan reads one frame entry
//     per cycle from the single read port of the stamp ram and runs it
//     through one shared stamp comparator
// Throughput: a new request may start in the cycle its result is shown.
// Reset: clears all tracked and evictable marks, the order clock and the
//   evictable total, and sets history_k to 2; the stamp ram is not cleared
//   and needs no clearing pass.
`include "assert_macros.svh"

module lru_k_frame_replacer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lkr_pkg::req_t                 in_req,
  output logic                          out_valid,
  output lkr_pkg::rsp_t                 out_rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lkr_pkg::CNT_W-1:0]     cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_UPD  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  lkr_pkg::req_t req_r, req_nxt;
  lkr_pkg::rsp_t rsp_r, rsp_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [lkr_pkg::CNT_W-1:0] history_k_r;
  logic [lkr_pkg::FRAME_COUNT-1:0] tracked_r, tracked_nxt;
  logic [lkr_pkg::FRAME_COUNT-1:0] evict_r, evict_nxt;
  logic [lkr_pkg::STAMP_W-1:0] clock_r, clock_nxt;
  logic [lkr_pkg::TOTAL_W-1:0] total_r, total_nxt;
  logic [lkr_pkg::FRAME_W:0] scan_cnt_r, scan_cnt_nxt;
  logic hist_vld_r, hist_vld_nxt, cache_vld_r, cache_vld_nxt;
  logic [lkr_pkg::FRAME_W-1:0] hist_idx_r, hist_idx_nxt, cache_idx_r, cache_idx_nxt;
  logic [lkr_pkg::STAMP_W-1:0] hist_stamp_r, hist_stamp_nxt;
  logic [lkr_pkg::STAMP_W-1:0] cache_stamp_r, cache_stamp_nxt;

  // stamp ram ports
  logic ram_we;
  logic [lkr_pkg::FRAME_W-1:0] ram_waddr, ram_raddr;
  lkr_pkg::entry_t ram_wentry, ram_rentry;
  logic [$bits(lkr_pkg::entry_t)-1:0] ram_wdata, ram_rdata;

  // helper values
  logic [lkr_pkg::CNT_W-1:0] k_eff;
  logic [lkr_pkg::STAMP_W-1:0] clock_inc;
  logic [lkr_pkg::FRAME_W-1:0] in_fidx, req_fidx;
  logic in_range;
  logic [lkr_pkg::FRAME_W:0] scan_prev;
  logic [lkr_pkg::FRAME_W-1:0] scan_idx;
  logic scan_done;
  logic scan_cand, in_cache, best_vld, take;
  logic [lkr_pkg::STAMP_W-1:0] best_stamp;
  logic vic_vld;
  logic [lkr_pkg::FRAME_W-1:0] vic_idx;
  logic [lkr_pkg::CNT_W-1:0] cnt_new;

  lkr_ram #(
    .WIDTH ($bits(lkr_pkg::entry_t)),
    .DEPTH (lkr_pkg::FRAME_COUNT)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_wdata  = ram_wentry;
  assign ram_rentry = ram_rdata;

  // effective k, never below two
  assign k_eff = (history_k_r < lkr_pkg::CNT_W'(lkr_pkg::K_MIN)) ?
                 lkr_pkg::CNT_W'(lkr_pkg::K_MIN) : history_k_r;
  assign clock_inc = clock_r + lkr_pkg::STAMP_W'(1);
  assign in_fidx   = in_req.frame_sel[lkr_pkg::FRAME_W-1:0];
  assign req_fidx  = req_r.frame_sel[lkr_pkg::FRAME_W-1:0];
  assign in_range  = {1'b0, in_req.frame_sel} < (lkr_pkg::ID_W+1)'(lkr_pkg::FRAME_COUNT);

  // shared scan comparator: entry read last cycle against its group's best
  assign scan_prev  = scan_cnt_r - 1'b1;
  assign scan_idx   = scan_prev[lkr_pkg::FRAME_W-1:0];
  assign scan_done  = (scan_cnt_r == (lkr_pkg::FRAME_W+1)'(lkr_pkg::FRAME_COUNT));
  assign scan_cand  = (scan_cnt_r != '0) && tracked_r[scan_idx] && evict_r[scan_idx];
  assign in_cache   = ram_rentry.count >= k_eff;
  assign best_vld   = in_cache ? cache_vld_r : hist_vld_r;
  assign best_stamp = in_cache ? cache_stamp_r : hist_stamp_r;
  assign take       = scan_cand && (!best_vld || (ram_rentry.stamp < best_stamp));

  // victim: oldest history frame first, else least recent cache frame
  assign vic_vld = hist_vld_r || cache_vld_r;
  assign vic_idx = hist_vld_r ? hist_idx_r : cache_idx_r;

  // saturating count for an access to a tracked frame
  assign cnt_new = (ram_rentry.count == lkr_pkg::CNT_W'(lkr_pkg::CNT_MAX)) ?
                   ram_rentry.count : ram_rentry.count + 1'b1;

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    rsp_nxt         = rsp_r;
    out_valid_nxt   = 1'b0;
    tracked_nxt     = tracked_r;
    evict_nxt       = evict_r;
    clock_nxt       = clock_r;
    total_nxt       = total_r;
    scan_cnt_nxt    = scan_cnt_r;
    hist_vld_nxt    = hist_vld_r;
    hist_idx_nxt    = hist_idx_r;
    hist_stamp_nxt  = hist_stamp_r;
    cache_vld_nxt   = cache_vld_r;
    cache_idx_nxt   = cache_idx_r;
    cache_stamp_nxt = cache_stamp_r;
    ram_we          = 1'b0;
    ram_waddr       = in_fidx;
    ram_wentry      = '0;
    ram_raddr       = (state_r == ST_SCAN) ? scan_cnt_r[lkr_pkg::FRAME_W-1:0] : in_fidx;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          req_nxt = in_req;
          rsp_nxt = '0;
          if (in_req.operation == lkr_pkg::OP_EVICT) begin
            state_nxt     = ST_SCAN;
            scan_cnt_nxt  = '0;
            hist_vld_nxt  = 1'b0;
            cache_vld_nxt = 1'b0;
          end else if (!in_range) begin
            rsp_nxt.status = lkr_pkg::STS_INVALID;
            out_valid_nxt  = 1'b1;
          end else begin
            case (in_req.operation)
              lkr_pkg::OP_RECORD: begin
                if (tracked_r[in_fidx]) begin
                  state_nxt = ST_UPD;
                end else if (total_r == lkr_pkg::TOTAL_W'(lkr_pkg::FRAME_COUNT)) begin
                  state_nxt     = ST_SCAN;
                  scan_cnt_nxt  = '0;
                  hist_vld_nxt  = 1'b0;
                  cache_vld_nxt = 1'b0;
                end else begin
                  // first access to a new frame
                  clock_nxt              = clock_inc;
                  tracked_nxt[in_fidx]   = 1'b1;
                  evict_nxt[in_fidx]     = 1'b0;
                  ram_we                 = 1'b1;
                  ram_waddr              = in_fidx;
                  ram_wentry.count       = lkr_pkg::CNT_W'(1);
                  ram_wentry.stamp       = clock_inc;
                  out_valid_nxt          = 1'b1;
                end
              end
              lkr_pkg::OP_SET_EV: begin
                if (tracked_r[in_fidx]) begin
                  if (!evict_r[in_fidx] && in_req.evictable_flag) begin
                    total_nxt = total_r + 1'b1;
                  end else if (evict_r[in_fidx] && !in_req.evictable_flag &&
                               (total_r != '0)) begin
                    total_nxt = total_r - 1'b1;
                  end
                  evict_nxt[in_fidx] = in_req.evictable_flag;
                end
                out_valid_nxt = 1'b1;
              end
              lkr_pkg::OP_REMOVE: begin
                if (tracked_r[in_fidx]) begin
                  if (!evict_r[in_fidx]) begin
                    rsp_nxt.status = lkr_pkg::STS_PINNED;
                  end else begin
                    if (total_r != '0) begin
                      total_nxt = total_r - 1'b1;
                    end
                    tracked_nxt[in_fidx] = 1'b0;
                    evict_nxt[in_fidx]   = 1'b0;
                  end
                end
                out_valid_nxt = 1'b1;
              end
              default: begin
                out_valid_nxt = 1'b1;
              end
            endcase
          end
        end
      end

      ST_UPD: begin
        // read-modify-write of a tracked frame's count and stamp
        clock_nxt        = clock_inc;
        ram_we           = 1'b1;
        ram_waddr        = req_fidx;
        ram_wentry.count = cnt_new;
        ram_wentry.stamp = (cnt_new >= k_eff) ? clock_inc : ram_rentry.stamp;
        out_valid_nxt    = 1'b1;
        state_nxt        = ST_IDLE;
      end

      ST_SCAN: begin
        if (take) begin
          if (in_cache) begin
            cache_vld_nxt   = 1'b1;
            cache_idx_nxt   = scan_idx;
            cache_stamp_nxt = ram_rentry.stamp;
          end else begin
            hist_vld_nxt    = 1'b1;
            hist_idx_nxt    = scan_idx;
            hist_stamp_nxt  = ram_rentry.stamp;
          end
        end
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_done) begin
          state_nxt = ST_FIN;
        end
      end

      ST_FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
        if (!vic_vld) begin
          rsp_nxt.status = lkr_pkg::STS_NO_VICTIM;
        end else begin
          // drop the victim
          if (evict_r[vic_idx] && (total_r != '0)) begin
            total_nxt = total_r - 1'b1;
          end
          tracked_nxt[vic_idx]  = 1'b0;
          evict_nxt[vic_idx]    = 1'b0;
          rsp_nxt.victim_valid  = 1'b1;
          rsp_nxt.victim_frame  = lkr_pkg::VFRAME_W'(vic_idx);
          // access to a new frame that waited for room
          if (req_r.operation == lkr_pkg::OP_RECORD) begin
            clock_nxt             = clock_inc;
            tracked_nxt[req_fidx] = 1'b1;
            evict_nxt[req_fidx]   = 1'b0;
            ram_we                = 1'b1;
            ram_waddr             = req_fidx;
            ram_wentry.count      = lkr_pkg::CNT_W'(1);
            ram_wentry.stamp      = clock_inc;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    rsp_nxt.evictable_count = out_valid_nxt ? total_nxt : rsp_r.evictable_count;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tracked_r   <= '0;
      evict_r     <= '0;
      clock_r     <= '0;
      total_r     <= '0;
      history_k_r <= lkr_pkg::CNT_W'(lkr_pkg::K_RESET);
      scan_cnt_r  <= '0;
      hist_vld_r  <= 1'b0;
      cache_vld_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tracked_r   <= tracked_nxt;
      evict_r     <= evict_nxt;
      clock_r     <= clock_nxt;
      total_r     <= total_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      hist_vld_r  <= hist_vld_nxt;
      cache_vld_r <= cache_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        history_k_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    rsp_r         <= rsp_nxt;
    hist_idx_r    <= hist_idx_nxt;
    hist_stamp_r  <= hist_stamp_nxt;
    cache_idx_r   <= cache_idx_nxt;
    cache_stamp_r <= cache_stamp_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  // checks
  `ASSERT_PROP(a_total_matches, ($countones(evict_r) == int'(total_r)), "evictable total mismatch")
  `ASSERT_NEVER(a_evict_untracked, (|(evict_r & ~tracked_r)), "evictable frame not tracked")
  `ASSERT_PROP(a_result_cause, (out_valid_r |-> $past(start || busy)), "result without a request")
  `ASSERT_PROP(a_scan_end, ((state_r == ST_SCAN) && scan_done |=> (state_r == ST_FIN)), "scan did not finish")

endmodule

/* rtl/lkr_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module lkr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* tb/sv/lru_k_frame_replacer_tb.sv */
// self-checking testbench for lru_k_frame_replacer: directed and random request traffic,
// history_k changes between phases, results checked against an in-bench replacer model
// depends on lkr_pkg and the lru_k_frame_replacer rtl
module lru_k_frame_replacer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  lkr_pkg::req_t               in_req;
  logic                        out_valid;
  lkr_pkg::rsp_t               out_rsp;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [lkr_pkg::CNT_W-1:0]   cfg_data;

  lru_k_frame_replacer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // requests waiting to be sent and results predicted for accepted transactions
  lkr_pkg::req_t request_backlog[$];
  lkr_pkg::rsp_t predicted_rsp[$];
  int unsigned   queued_total;
  int unsigned   sender_idle_pct;
  int unsigned   mismatch_count;
  lkr_pkg::rsp_t oldest_rsp;

  // replacer model state
  bit                        frame_tracked   [lkr_pkg::FRAME_COUNT];
  bit                        frame_evictable [lkr_pkg::FRAME_COUNT];
  logic [lkr_pkg::CNT_W-1:0] frame_hits      [lkr_pkg::FRAME_COUNT];
  logic [31:0]               frame_stamp     [lkr_pkg::FRAME_COUNT];
  logic [31:0]               access_clock;
  int unsigned               evictable_frames;
  logic [lkr_pkg::CNT_W-1:0] history_k_model;

  int unsigned k_plan[9];
  int unsigned idle_plan[9];

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #(10_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  // history_k values below the minimum act as the minimum
  function automatic int unsigned effective_k();
    return (history_k_model < lkr_pkg::K_MIN) ? lkr_pkg::K_MIN : history_k_model;
  endfunction

  // oldest evictable history frame, else least recent evictable cache frame; -1 if none
  function automatic int pick_victim();
    int          best;
    logic [31:0] best_stamp;
    int unsigned k_eff;
    k_eff = effective_k();
    for (int grp = 0; grp < 2; grp++) begin
      best = -1;
      best_stamp = '0;
      for (int i = 0; i < lkr_pkg::FRAME_COUNT; i++) begin
        if (frame_tracked[i] && frame_evictable[i] &&
            ((frame_hits[i] >= k_eff) == (grp == 1))) begin
          if (best < 0 || frame_stamp[i] < best_stamp) begin
            best = i;
            best_stamp = frame_stamp[i];
          end
        end
      end
      if (best >= 0) return best;
    end
    return -1;
  endfunction

  function automatic void untrack_frame(int i);
    if (frame_evictable[i] && evictable_frames > 0) evictable_frames--;
    frame_tracked[i]   = 1'b0;
    frame_evictable[i] = 1'b0;
    frame_hits[i]      = '0;
  endfunction

  // apply one request to the model and return the result it gives
  function automatic lkr_pkg::rsp_t predict_replacer(lkr_pkg::req_t r);
    lkr_pkg::rsp_t res;
    int            victim;
    int unsigned   fid;
    bit            admit;
    res = '0;
    fid = r.frame_sel;
    if (r.operation == lkr_pkg::OP_EVICT) begin
      victim = pick_victim();
      if (victim < 0) begin
        res.status = lkr_pkg::STS_NO_VICTIM;
      end else begin
        untrack_frame(victim);
        res.victim_valid = 1'b1;
        res.victim_frame = lkr_pkg::VFRAME_W'(victim);
      end
    end else if (fid >= lkr_pkg::FRAME_COUNT) begin
      res.status = lkr_pkg::STS_INVALID;
    end else if (r.operation == lkr_pkg::OP_RECORD) begin
      if (!frame_tracked[fid]) begin
        admit = 1'b1;
        // table full of evictable frames: make room first
        if (evictable_frames == lkr_pkg::FRAME_COUNT) begin
          victim = pick_victim();
          if (victim < 0) begin
            admit = 1'b0;
            res.status = lkr_pkg::STS_NO_VICTIM;
          end else begin
            untrack_frame(victim);
            res.victim_valid = 1'b1;
            res.victim_frame = lkr_pkg::VFRAME_W'(victim);
          end
        end
        if (admit) begin
          access_clock++;
          frame_tracked[fid]   = 1'b1;
          frame_evictable[fid] = 1'b0;
          frame_hits[fid]      = 1;
          frame_stamp[fid]     = access_clock;
        end
      end else begin
        access_clock++;
        if (frame_hits[fid] < lkr_pkg::CNT_MAX) frame_hits[fid]++;
        if (frame_hits[fid] >= effective_k()) frame_stamp[fid] = access_clock;
      end
    end else if (r.operation == lkr_pkg::OP_SET_EV) begin
      if (frame_tracked[fid]) begin
        if (!frame_evictable[fid] && r.evictable_flag) evictable_frames++;
        else if (frame_evictable[fid] && !r.evictable_flag && evictable_frames > 0)
          evictable_frames--;
        frame_evictable[fid] = r.evictable_flag;
      end
    end else begin
      if (frame_tracked[fid]) begin
        if (!frame_evictable[fid]) res.status = lkr_pkg::STS_PINNED;
        else untrack_frame(fid);
      end
    end
    res.evictable_count = lkr_pkg::TOTAL_W'(evictable_frames);
    return res;
  endfunction

  function automatic void queue_req(logic [1:0] op, int unsigned fid, bit flag);
    lkr_pkg::req_t r;
    r.operation      = op;
    r.frame_sel      = lkr_pkg::ID_W'(fid);
    r.evictable_flag = flag;
    request_backlog.push_back(r);
    queued_total++;
  endfunction

  // mostly a small working set so frames get reused and promoted
  function automatic int unsigned pick_frame();
    if ($urandom_range(3) != 0) return $urandom_range(15);
    return $urandom_range(lkr_pkg::FRAME_COUNT - 1);
  endfunction

  // nothing queued, nothing in flight
  task automatic wait_drained();
    while (request_backlog.size() != 0 || predicted_rsp.size() != 0 || start)
      @(posedge clk);
  endtask

  // driver: predict on acceptance, then present the next request or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start  <= 1'b0;
      in_req <= '0;
    end else begin
      if (start && busy === 1'b0)
        predicted_rsp.push_back(predict_replacer(in_req));
      if (!start || busy === 1'b0) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_req <= request_backlog.pop_front();
          start  <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every result against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (predicted_rsp.size() == 0) begin
        $error("result with no transaction outstanding: %p", out_rsp);
        mismatch_count++;
      end else begin
        oldest_rsp = predicted_rsp.pop_front();
        if (out_rsp.status !== oldest_rsp.status) begin
          $error("status: expected %0d, got %0d", oldest_rsp.status, out_rsp.status);
          mismatch_count++;
        end
        if (out_rsp.victim_valid !== oldest_rsp.victim_valid) begin
          $error("victim_valid: expected %0d, got %0d",
                 oldest_rsp.victim_valid, out_rsp.victim_valid);
          mismatch_count++;
        end
        if (out_rsp.victim_frame !== oldest_rsp.victim_frame) begin
          $error("victim_frame: expected %0d, got %0d",
                 oldest_rsp.victim_frame, out_rsp.victim_frame);
          mismatch_count++;
        end
        if (out_rsp.evictable_count !== oldest_rsp.evictable_count) begin
          $error("evictable_count: expected %0d, got %0d",
                 oldest_rsp.evictable_count, out_rsp.evictable_count);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus and phase control
  initial begin
    int unsigned p;
    int unsigned sel;
    int unsigned reps;
    int unsigned fid;
    int unsigned target;

    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    sender_idle_pct = 0;
    queued_total    = 0;
    mismatch_count  = 0;
    k_plan    = '{15, 0, 1, 3, 8, 2, 7, 14, 2};
    idle_plan = '{0, 88, 18, 0, 88, 18, 0, 88, 18};

    // model starts from the reset state
    for (int i = 0; i < lkr_pkg::FRAME_COUNT; i++) begin
      frame_tracked[i]   = 1'b0;
      frame_evictable[i] = 1'b0;
      frame_hits[i]      = '0;
      frame_stamp[i]     = '0;
    end
    access_clock     = '0;
    evictable_frames = 0;
    history_k_model  = lkr_pkg::K_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, range checks, pinned remove, group order, mark toggling
    queue_req(lkr_pkg::OP_EVICT,  0,   1'b0);
    queue_req(lkr_pkg::OP_RECORD, 0,   1'b0);
    queue_req(lkr_pkg::OP_RECORD, 63,  1'b0);
    queue_req(lkr_pkg::OP_RECORD, 64,  1'b0);
    queue_req(lkr_pkg::OP_RECORD, 255, 1'b1);
    queue_req(lkr_pkg::OP_SET_EV, 128, 1'b1);
    queue_req(lkr_pkg::OP_REMOVE, 200, 1'b0);
    queue_req(lkr_pkg::OP_SET_EV, 5,   1'b1);
    queue_req(lkr_pkg::OP_REMOVE, 5,   1'b0);
    queue_req(lkr_pkg::OP_REMOVE, 0,   1'b0);
    queue_req(lkr_pkg::OP_RECORD, 0,   1'b0);
    queue_req(lkr_pkg::OP_SET_EV, 0,   1'b1);
    queue_req(lkr_pkg::OP_SET_EV, 63,  1'b1);
    queue_req(lkr_pkg::OP_SET_EV, 63,  1'b1);
    queue_req(lkr_pkg::OP_EVICT,  0,   1'b0);
    queue_req(lkr_pkg::OP_EVICT,  0,   1'b0);
    queue_req(lkr_pkg::OP_EVICT,  0,   1'b0);
    queue_req(lkr_pkg::OP_RECORD, 10,  1'b0);
    queue_req(lkr_pkg::OP_SET_EV, 10,  1'b1);
    queue_req(lkr_pkg::OP_SET_EV, 10,  1'b0);
    queue_req(lkr_pkg::OP_SET_EV, 10,  1'b1);
    queue_req(lkr_pkg::OP_REMOVE, 10,  1'b0);
    queue_req(lkr_pkg::OP_EVICT,  255, 1'b1);

    for (p = 0; p < 9; p++) begin
      // history_k changes only with nothing in flight
      wait_drained();
      repeat (4) @(posedge clk);
      cfg_data  <= lkr_pkg::CNT_W'(k_plan[p]);
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
      cfg_valid <= 1'b0;
      history_k_model = lkr_pkg::CNT_W'(k_plan[p]);
      sender_idle_pct = idle_plan[p];

      // once: every frame tracked and evictable, so the table is full
      if (p == 3) begin
        for (fid = 0; fid < lkr_pkg::FRAME_COUNT; fid++) begin
          queue_req(lkr_pkg::OP_RECORD, fid, 1'b0);
          queue_req(lkr_pkg::OP_SET_EV, fid, 1'b1);
        end
      end

      target = queued_total + 180;
      while (queued_total < target) begin
        sel = $urandom_range(99);
        if (sel < 30) begin
          // a frame is accessed one or more times and is then released
          fid  = pick_frame();
          reps = ($urandom_range(7) == 0) ? $urandom_range(18, 13) : $urandom_range(4, 1);
          repeat (reps) queue_req(lkr_pkg::OP_RECORD, fid, $urandom_range(1));
          queue_req(lkr_pkg::OP_SET_EV, fid, 1'b1);
        end else if (sel < 40) begin
          // run of evictions
          repeat ($urandom_range(4, 1))
            queue_req(lkr_pkg::OP_EVICT, $urandom_range(255), $urandom_range(1));
        end else begin
          // single request of any kind, now and then out of range
          fid = ($urandom_range(9) == 0) ? $urandom_range(255) : pick_frame();
          queue_req(2'($urandom_range(3)), fid, $urandom_range(1));
        end
      end
    end

    wait_drained();
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/lkr_pkg.sv
rtl/lkr_ram.sv
rtl/lru_k_frame_replacer.sv
tb/sv/lru_k_frame_replacer_tb.sv
